@@ rtl/obm_pkg.sv @@
// ---------------------------------------------------------------------------
// obm_pkg
// Shared types, sizes and box arithmetic for the overlapping box merge unit.
// ---------------------------------------------------------------------------
package obm_pkg;

   // table and coordinate sizes
   localparam int TABLE_DEPTH = 16;
   localparam int COORD_BITS  = 12;
   localparam int SIZE_BITS   = COORD_BITS + 1;
   localparam int END_BITS    = SIZE_BITS + 1;
   localparam int AREA_BITS   = 2 * SIZE_BITS;
   localparam int CMP_BITS    = AREA_BITS + 3;
   localparam int STEP_BITS   = $clog2(TABLE_DEPTH + 1);

   // stream payload layout
   localparam int DATA_BITS   = 2 * COORD_BITS + 2 * SIZE_BITS;
   localparam int TDATA_BITS  = ((DATA_BITS + 7) / 8) * 8;
   localparam int TUSER_BITS  = 2;

   localparam logic [SIZE_BITS-1:0] SIZE_MAX = SIZE_BITS'(1) << COORD_BITS;

   typedef struct packed {
      logic [SIZE_BITS-1:0]  h;
      logic [SIZE_BITS-1:0]  w;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] x;
   } box_type;

   typedef struct packed {
      logic    valid;
      box_type box;
   } entry_type;

   // control from the sequencer to the compare unit
   typedef struct packed {
      logic shift;
      logic check;
      logic clear;
      logic placed;
   } probe_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MERGE,
      ST_READ
   } state_type;

   // clamp a size to the largest legal size
   function automatic logic [SIZE_BITS-1:0] sat_size(logic [END_BITS-1:0] v);
      logic [SIZE_BITS-1:0] r;
      if (v > END_BITS'(SIZE_MAX)) begin
         r = SIZE_MAX;
      end else begin
         r = v[SIZE_BITS-1:0];
      end
      return r;
   endfunction

   // bounding union, an empty box gives way to the other one
   function automatic box_type box_union(box_type a, box_type b);
      logic [END_BITS-1:0]   ax2;
      logic [END_BITS-1:0]   bx2;
      logic [END_BITS-1:0]   ay2;
      logic [END_BITS-1:0]   by2;
      logic [END_BITS-1:0]   x2;
      logic [END_BITS-1:0]   y2;
      logic [COORD_BITS-1:0] rx;
      logic [COORD_BITS-1:0] ry;
      box_type               r;
      ax2 = END_BITS'(a.x) + END_BITS'(a.w);
      bx2 = END_BITS'(b.x) + END_BITS'(b.w);
      ay2 = END_BITS'(a.y) + END_BITS'(a.h);
      by2 = END_BITS'(b.y) + END_BITS'(b.h);
      rx  = (a.x < b.x) ? a.x : b.x;
      ry  = (a.y < b.y) ? a.y : b.y;
      x2  = (ax2 > bx2) ? ax2 : bx2;
      y2  = (ay2 > by2) ? ay2 : by2;
      r.x = rx;
      r.y = ry;
      r.w = sat_size(x2 - END_BITS'(rx));
      r.h = sat_size(y2 - END_BITS'(ry));
      if (a.w == '0 || a.h == '0) begin
         r = b;
      end else if (b.w == '0 || b.h == '0) begin
         r = a;
      end
      return r;
   endfunction

   // overlap length of two spans on one axis
   function automatic logic [SIZE_BITS-1:0] span_overlap(logic [COORD_BITS-1:0] a0,
                                                        logic [SIZE_BITS-1:0]  al,
                                                        logic [COORD_BITS-1:0] b0,
                                                        logic [SIZE_BITS-1:0]  bl);
      logic [END_BITS-1:0]   a1;
      logic [END_BITS-1:0]   b1;
      logic [END_BITS-1:0]   hi;
      logic [END_BITS-1:0]   lo;
      logic [SIZE_BITS-1:0]  r;
      a1 = END_BITS'(a0) + END_BITS'(al);
      b1 = END_BITS'(b0) + END_BITS'(bl);
      lo = (a0 > b0) ? END_BITS'(a0) : END_BITS'(b0);
      hi = (a1 < b1) ? a1 : b1;
      if (hi > lo) begin
         r = SIZE_BITS'(hi - lo);
      end else begin
         r = '0;
      end
      return r;
   endfunction

endpackage

@@ rtl/obm_cell.sv @@
// ---------------------------------------------------------------------------
// obm_cell
// One slot of the box ring: holds a box and its valid bit and takes its
// neighbor's entry whenever the ring shifts.
// ---------------------------------------------------------------------------
module obm_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               shift,
   input  obm_pkg::entry_type d,
   output obm_pkg::entry_type q
);

   logic             valid_ff;
   logic             valid_in;
   obm_pkg::box_type box_ff;
   obm_pkg::box_type box_in;

   // hold or take the neighbor
   always_comb begin
      valid_in = shift ? d.valid : valid_ff;
      box_in   = shift ? d.box : box_ff;
   end

   // valid bit is control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // box payload
   always_ff @(posedge clock) begin
      box_ff <= box_in;
   end

   assign q.valid = valid_ff;
   assign q.box   = box_ff;

endmodule

@@ rtl/obm_probe.sv @@
// ---------------------------------------------------------------------------
// obm_probe
// Compare slot of the ring: takes the head entry, works out overlap and area
// against the query box, then decides the entry written back to the tail.
// ---------------------------------------------------------------------------
module obm_probe (
   input  logic                            clock,
   input  logic                            reset,
   input  obm_pkg::probe_ctrl_type         ctrl,
   input  obm_pkg::box_type                query,
   input  logic [obm_pkg::AREA_BITS-1:0]   query_area,
   input  obm_pkg::entry_type              head,
   output obm_pkg::entry_type              slot,
   output obm_pkg::entry_type              wb,
   output logic                            place
);

   logic                          slot_valid_ff;
   logic                          slot_valid_in;
   obm_pkg::box_type              slot_box_ff;
   obm_pkg::box_type              union_ff;
   logic [obm_pkg::AREA_BITS-1:0] area_ff;
   logic [obm_pkg::SIZE_BITS-1:0] ov_w_ff;
   logic [obm_pkg::SIZE_BITS-1:0] ov_h_ff;

   logic [obm_pkg::AREA_BITS-1:0] ov_area;
   logic [obm_pkg::CMP_BITS-1:0]  ov5;
   logic [obm_pkg::CMP_BITS-1:0]  in4;
   logic [obm_pkg::CMP_BITS-1:0]  st4;
   logic                          match;

   assign slot_valid_in = ctrl.shift ? head.valid : slot_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
      end
   end

   // first stage: overlap spans, stored area and union from the head entry
   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         slot_box_ff <= head.box;
         area_ff     <= head.box.w * head.box.h;
         ov_w_ff     <= obm_pkg::span_overlap(query.x, query.w, head.box.x, head.box.w);
         ov_h_ff     <= obm_pkg::span_overlap(query.y, query.h, head.box.y, head.box.h);
         union_ff    <= obm_pkg::box_union(query, head.box);
      end
   end

   // second stage: 5 * overlap against 4 * either area
   always_comb begin
      ov_area = ov_w_ff * ov_h_ff;
      ov5     = (obm_pkg::CMP_BITS'(ov_area) << 2) + obm_pkg::CMP_BITS'(ov_area);
      in4     = obm_pkg::CMP_BITS'(query_area) << 2;
      st4     = obm_pkg::CMP_BITS'(area_ff) << 2;
      match   = slot_valid_ff && (ov5 > in4 || ov5 > st4);
   end

   // write-back: merge, append at the first free slot, clear, or pass on
   always_comb begin
      place    = ctrl.check && !ctrl.placed && (match || !slot_valid_ff);
      wb.valid = slot_valid_ff;
      wb.box   = slot_box_ff;
      if (ctrl.clear) begin
         wb.valid = 1'b0;
      end else if (place) begin
         wb.valid = 1'b1;
         wb.box   = slot_valid_ff ? union_ff : query;
      end
   end

   assign slot.valid = slot_valid_ff;
   assign slot.box   = slot_box_ff;

endmodule

@@ rtl/overlapping_box_merge_unit.sv @@
// ---------------------------------------------------------------------------
// overlapping_box_merge_unit
// Merges overlapping boxes of a frame in a ring of table cells and reads
// the merged boxes out at the end of the frame.
// ---------------------------------------------------------------------------
// Usage:
//   req channel carries one box per request; req_tlast marks the last box
//   of a frame. rsp channel carries the merged boxes of the frame in table
//   order, one request each, rsp_tlast on the last one.
//   Each box is held as the query while the table travels once around a
//   ring of TABLE_DEPTH cells plus one compare slot; the next request is
//   taken only after that lap is complete. On the last box of a frame a
//   second lap sends one rsp request per stored box, and the next box is
//   taken only after that lap too. While a rsp request is pending at a
//   stalled receiver and another stored box waits to be sent, that lap
//   holds. One output register holds the last rsp request while a new
//   request is already taken.
//   Reset empties the table and clears the overflow flag; no rsp request
//   is pending after reset.
// ---------------------------------------------------------------------------
module overlapping_box_merge_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   // box_x, box_y, box_width, box_height
   input  logic [obm_pkg::TDATA_BITS-1:0]       req_tdata,
   input  logic                                 req_tlast,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // merged_x, merged_y, merged_width, merged_height
   output logic [obm_pkg::TDATA_BITS-1:0]       rsp_tdata,
   // entry_valid, table_overflowed
   output logic [obm_pkg::TUSER_BITS-1:0]       rsp_tuser,
   output logic                                 rsp_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready
);

   localparam int XL = 0;
   localparam int YL = obm_pkg::COORD_BITS;
   localparam int WL = 2 * obm_pkg::COORD_BITS;
   localparam int HL = 2 * obm_pkg::COORD_BITS + obm_pkg::SIZE_BITS;

   obm_pkg::state_type            state_ff;
   obm_pkg::state_type            state_in;
   logic [obm_pkg::STEP_BITS-1:0] step_ff;
   logic [obm_pkg::STEP_BITS-1:0] step_in;
   logic                          placed_ff;
   logic                          placed_in;
   logic                          overflow_ff;
   logic                          overflow_in;
   logic                          frame_end_ff;
   logic                          frame_end_in;
   obm_pkg::box_type              query_ff;
   obm_pkg::box_type              query_in;
   logic [obm_pkg::AREA_BITS-1:0] area_ff;
   logic [obm_pkg::AREA_BITS-1:0] area_in;
   logic                          out_valid_ff;
   logic                          out_valid_in;
   obm_pkg::box_type              out_box_ff;
   obm_pkg::box_type              out_box_in;
   logic                          out_ovf_ff;
   logic                          out_ovf_in;
   logic                          out_last_ff;
   logic                          out_last_in;

   obm_pkg::entry_type            cell_q [obm_pkg::TABLE_DEPTH];
   obm_pkg::entry_type            slot;
   obm_pkg::entry_type            wb;
   logic                          place;
   obm_pkg::probe_ctrl_type       ctrl;
   logic                          req_take;
   logic                          emit;
   logic                          last_step;
   obm_pkg::box_type              req_box;

   // unpack the request and clamp sizes
   always_comb begin
      req_box.x = req_tdata[YL-1:XL];
      req_box.y = req_tdata[WL-1:YL];
      req_box.w = obm_pkg::sat_size(obm_pkg::END_BITS'(req_tdata[HL-1:WL]));
      req_box.h = obm_pkg::sat_size(
                     obm_pkg::END_BITS'(req_tdata[obm_pkg::DATA_BITS-1:HL]));
   end

   // ring of table cells, the compare slot sits between cell 0 and the tail
   for (genvar i = 0; i < obm_pkg::TABLE_DEPTH; i++) begin : g_ring
      obm_pkg::entry_type cell_d;
      if (i == obm_pkg::TABLE_DEPTH - 1) begin : g_tail
         assign cell_d = wb;
      end else begin : g_body
         assign cell_d = cell_q[i+1];
      end
      obm_cell u_cell (
         .clock (clock),
         .reset (reset),
         .shift (ctrl.shift),
         .d     (cell_d),
         .q     (cell_q[i])
      );
   end

   obm_probe u_probe (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .query      (query_ff),
      .query_area (area_ff),
      .head       (cell_q[0]),
      .slot       (slot),
      .wb         (wb),
      .place      (place)
   );

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= obm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // sequencer: next state, ring control and rsp request loading
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      placed_in    = placed_ff;
      overflow_in  = overflow_ff;
      frame_end_in = frame_end_ff;
      query_in     = query_ff;
      area_in      = area_ff;
      out_box_in   = out_box_ff;
      out_ovf_in   = out_ovf_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      req_take     = 1'b0;
      emit         = 1'b0;
      last_step    = (step_ff == obm_pkg::STEP_BITS'(obm_pkg::TABLE_DEPTH));
      ctrl.shift   = 1'b0;
      ctrl.check   = 1'b0;
      ctrl.clear   = 1'b0;
      ctrl.placed  = placed_ff;
      case (state_ff)
         obm_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            req_take   = req_tvalid;
            if (req_take) begin
               query_in     = req_box;
               area_in      = req_box.w * req_box.h;
               frame_end_in = req_tlast;
               placed_in    = 1'b0;
               step_in      = '0;
               state_in     = obm_pkg::ST_MERGE;
            end
         end
         obm_pkg::ST_MERGE: begin
            ctrl.shift = 1'b1;
            ctrl.check = (step_ff != '0);
            placed_in  = placed_ff || place;
            step_in    = step_ff + 1'b1;
            if (last_step) begin
               step_in     = '0;
               overflow_in = overflow_ff || !(placed_ff || place);
               state_in    = frame_end_ff ? obm_pkg::ST_READ : obm_pkg::ST_IDLE;
            end
         end
         obm_pkg::ST_READ: begin
            ctrl.clear = 1'b1;
            emit       = (step_ff != '0) && slot.valid;
            ctrl.shift = !(emit && out_valid_ff && !rsp_tready);
            if (ctrl.shift) begin
               step_in = step_ff + 1'b1;
               if (emit) begin
                  out_valid_in = 1'b1;
                  out_box_in   = slot.box;
                  out_ovf_in   = overflow_ff;
                  out_last_in  = !cell_q[0].valid;
               end
               if (last_step) begin
                  step_in     = '0;
                  overflow_in = 1'b0;
                  state_in    = obm_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = obm_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         placed_ff    <= 1'b0;
         overflow_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         placed_ff    <= placed_in;
         overflow_ff  <= overflow_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      frame_end_ff <= frame_end_in;
      query_ff     <= query_in;
      area_ff      <= area_in;
      out_box_ff   <= out_box_in;
      out_ovf_ff   <= out_ovf_in;
      out_last_ff  <= out_last_in;
   end

   // rsp channel
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = obm_pkg::TDATA_BITS'({out_box_ff.h, out_box_ff.w,
                                             out_box_ff.y, out_box_ff.x});
   assign rsp_tuser  = {out_ovf_ff, 1'b1};
   assign rsp_tlast  = out_last_ff;

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the overlapping box merge unit. A short table of
// directed frames comes first, then random frames of clustered, fresh, empty
// and raw boxes. Each readout is checked against a software copy of the merge
// table or a typed row's entry, under several sender and receiver idling phases.
// ---------------------------------------------------------------------------
module tb_top;

   localparam int CLOCK_HALF   = 2;
   localparam int RESET_CYCLES = 7;
   localparam int RANDOM_BOXES = 360;
   localparam int FRAMES_PER_PHASE = 6;
   localparam int DRAIN_CYCLES = 60;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int MAX_SIZE     = 1 << obm_pkg::COORD_BITS;
   localparam int MAX_COORD    = MAX_SIZE - 1;
   localparam int MAX_RAW_SIZE = (1 << obm_pkg::SIZE_BITS) - 1;

   // one readout request as the receiver sees it
   typedef struct packed {
      logic [obm_pkg::COORD_BITS-1:0] x;
      logic [obm_pkg::COORD_BITS-1:0] y;
      logic [obm_pkg::SIZE_BITS-1:0]  w;
      logic [obm_pkg::SIZE_BITS-1:0]  h;
      logic                           entry_valid;
      logic                           overflowed;
      logic                           final_entry;
   } readout_entry_type;

   // one row of the directed table
   typedef struct {
      obm_pkg::box_type  b;
      logic              frame_end;
      bit                typed;
      readout_entry_type want;
   } stim_row_type;

   logic                           clock;
   logic                           reset;
   logic [obm_pkg::TDATA_BITS-1:0] req_tdata;
   logic                           req_tlast;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [obm_pkg::TDATA_BITS-1:0] rsp_tdata;
   logic [obm_pkg::TUSER_BITS-1:0] rsp_tuser;
   logic                           rsp_tlast;
   logic                           rsp_tvalid;
   logic                           rsp_tready;

   // merge table copy
   obm_pkg::box_type  merged_table [obm_pkg::TABLE_DEPTH];
   int                merged_count = 0;
   logic              dropped_flag = 1'b0;
   readout_entry_type frame_readout [$];
   readout_entry_type expected_readout [$];
   obm_pkg::box_type  frame_sent [$];
   stim_row_type      directed_rows [$];

   int idle_pct    = 0;
   int stall_pct   = 0;
   int mismatches  = 0;
   int cycle_count = 0;

   overlapping_box_merge_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic logic [obm_pkg::SIZE_BITS-1:0] clamp_size(
         logic [obm_pkg::SIZE_BITS-1:0] v);
      return (v > MAX_SIZE) ? obm_pkg::SIZE_BITS'(MAX_SIZE) : v;
   endfunction

   // intersection area, zero when the boxes do not overlap
   function automatic longint overlap_of(obm_pkg::box_type a, obm_pkg::box_type b);
      longint lo_x;
      longint lo_y;
      longint hi_x;
      longint hi_y;
      lo_x = longint'((a.x > b.x) ? a.x : b.x);
      lo_y = longint'((a.y > b.y) ? a.y : b.y);
      hi_x = longint'(a.x) + a.w;
      if (longint'(b.x) + b.w < hi_x) hi_x = longint'(b.x) + b.w;
      hi_y = longint'(a.y) + a.h;
      if (longint'(b.y) + b.h < hi_y) hi_y = longint'(b.y) + b.h;
      if (hi_x <= lo_x || hi_y <= lo_y) return 0;
      return (hi_x - lo_x) * (hi_y - lo_y);
   endfunction

   // bounding union, an empty box yields the other one
   function automatic obm_pkg::box_type bounding_box(obm_pkg::box_type a,
                                                     obm_pkg::box_type b);
      longint           right;
      longint           bottom;
      obm_pkg::box_type r;
      if (a.w == 0 || a.h == 0) return b;
      if (b.w == 0 || b.h == 0) return a;
      r.x = (a.x < b.x) ? a.x : b.x;
      r.y = (a.y < b.y) ? a.y : b.y;
      right = longint'(a.x) + a.w;
      if (longint'(b.x) + b.w > right) right = longint'(b.x) + b.w;
      bottom = longint'(a.y) + a.h;
      if (longint'(b.y) + b.h > bottom) bottom = longint'(b.y) + b.h;
      r.w = (right - r.x > MAX_SIZE) ? obm_pkg::SIZE_BITS'(MAX_SIZE)
                                     : obm_pkg::SIZE_BITS'(right - r.x);
      r.h = (bottom - r.y > MAX_SIZE) ? obm_pkg::SIZE_BITS'(MAX_SIZE)
                                      : obm_pkg::SIZE_BITS'(bottom - r.y);
      return r;
   endfunction

   // merge one box into the table; on frame end fill frame_readout and clear
   task automatic fold_box(input obm_pkg::box_type raw, input logic frame_end);
      obm_pkg::box_type  nb;
      longint            area_in;
      longint            area_s;
      longint            ov;
      bit                fused;
      int                j;
      readout_entry_type e;
      nb = raw;
      nb.w = clamp_size(raw.w);
      nb.h = clamp_size(raw.h);
      area_in = longint'(nb.w) * nb.h;
      fused = 1'b0;
      frame_readout.delete();
      for (j = 0; j < merged_count && !fused; j++) begin
         ov = overlap_of(nb, merged_table[j]);
         area_s = longint'(merged_table[j].w) * merged_table[j].h;
         if (5 * ov > 4 * area_in || 5 * ov > 4 * area_s) begin
            merged_table[j] = bounding_box(nb, merged_table[j]);
            fused = 1'b1;
         end
      end
      if (!fused) begin
         if (merged_count < obm_pkg::TABLE_DEPTH) begin
            merged_table[merged_count] = nb;
            merged_count++;
         end else begin
            dropped_flag = 1'b1;
         end
      end
      if (!frame_end) return;
      // empty table still answers with one invalid entry
      if (merged_count == 0) begin
         e = '0;
         e.overflowed = dropped_flag;
         e.final_entry = 1'b1;
         frame_readout.insert(frame_readout.size(), e);
      end
      for (j = 0; j < merged_count; j++) begin
         e.x = merged_table[j].x;
         e.y = merged_table[j].y;
         e.w = merged_table[j].w;
         e.h = merged_table[j].h;
         e.entry_valid = 1'b1;
         e.overflowed = dropped_flag;
         e.final_entry = (j == merged_count - 1);
         frame_readout.insert(frame_readout.size(), e);
      end
      merged_count = 0;
      dropped_flag = 1'b0;
   endtask

   task automatic add_row(input int x, input int y, input int w, input int h,
                          input logic frame_end, input bit typed,
                          input readout_entry_type want);
      stim_row_type r;
      r.b.x = obm_pkg::COORD_BITS'(x);
      r.b.y = obm_pkg::COORD_BITS'(y);
      r.b.w = obm_pkg::SIZE_BITS'(w);
      r.b.h = obm_pkg::SIZE_BITS'(h);
      r.frame_end = frame_end;
      r.typed = typed;
      r.want = want;
      directed_rows.insert(directed_rows.size(), r);
   endtask

   // move v by up to span either way, kept within 0..top
   function automatic int nudge(int v, int span, int top);
      int d;
      int r;
      d = int'($urandom_range(2 * span));
      r = v + d - span;
      if (r < 0) r = 0;
      if (r > top) r = top;
      return r;
   endfunction

   function automatic obm_pkg::box_type random_box();
      obm_pkg::box_type p;
      obm_pkg::box_type r;
      int               kind;
      int               corner;
      kind = int'($urandom_range(99));
      if (kind < 45 && frame_sent.size() > 0) begin
         // near copy of a box already in this frame, likely to merge
         p = frame_sent[$urandom_range(frame_sent.size() - 1)];
         r.x = obm_pkg::COORD_BITS'(nudge(int'(p.x), int'(p.w) / 8 + 1, MAX_COORD));
         r.y = obm_pkg::COORD_BITS'(nudge(int'(p.y), int'(p.h) / 8 + 1, MAX_COORD));
         r.w = obm_pkg::SIZE_BITS'(nudge(int'(p.w), int'(p.w) / 8 + 1, MAX_RAW_SIZE));
         r.h = obm_pkg::SIZE_BITS'(nudge(int'(p.h), int'(p.h) / 8 + 1, MAX_RAW_SIZE));
      end else if (kind < 75) begin
         // fresh box, often in one corner so clusters form
         corner = $urandom_range(1) ? 511 : MAX_COORD;
         r.x = obm_pkg::COORD_BITS'($urandom_range(corner));
         r.y = obm_pkg::COORD_BITS'($urandom_range(corner));
         r.w = obm_pkg::SIZE_BITS'($urandom_range(1, 300));
         r.h = obm_pkg::SIZE_BITS'($urandom_range(1, 300));
      end else if (kind < 85) begin
         // empty box
         r.x = obm_pkg::COORD_BITS'($urandom_range(MAX_COORD));
         r.y = obm_pkg::COORD_BITS'($urandom_range(MAX_COORD));
         r.w = obm_pkg::SIZE_BITS'($urandom_range(300));
         r.h = obm_pkg::SIZE_BITS'($urandom_range(300));
         if ($urandom_range(1)) r.w = '0;
         else r.h = '0;
      end else begin
         // raw field values, sizes may go past the legal maximum
         r.x = obm_pkg::COORD_BITS'($urandom_range(MAX_COORD));
         r.y = obm_pkg::COORD_BITS'($urandom_range(MAX_COORD));
         r.w = obm_pkg::SIZE_BITS'($urandom_range(MAX_RAW_SIZE));
         r.h = obm_pkg::SIZE_BITS'($urandom_range(MAX_RAW_SIZE));
      end
      return r;
   endfunction

   // drive one request, then predict once it is taken
   task automatic send_box(input obm_pkg::box_type b, input logic frame_end,
                           input bit typed, input readout_entry_type want);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= obm_pkg::TDATA_BITS'(b);
      req_tlast  <= frame_end;
      do @(posedge clock); while (!req_tready);
      fold_box(b, frame_end);
      if (typed) begin
         expected_readout.insert(expected_readout.size(), want);
      end else begin
         foreach (frame_readout[k]) begin
            expected_readout.insert(expected_readout.size(), frame_readout[k]);
         end
      end
      @(negedge clock);
   endtask

   task automatic check_field(input string name,
                              input logic [obm_pkg::SIZE_BITS-1:0] want,
                              input logic [obm_pkg::SIZE_BITS-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // receiver back-pressure
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // rsp checker
   always @(posedge clock) begin
      readout_entry_type want;
      obm_pkg::box_type  got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[obm_pkg::DATA_BITS-1:0];
         if (expected_readout.size() == 0) begin
            $error("rsp request with nothing pending: x=%0d y=%0d w=%0d h=%0d",
                   got.x, got.y, got.w, got.h);
            mismatches++;
         end else begin
            want = expected_readout.pop_front();
            check_field("merged_x", obm_pkg::SIZE_BITS'(want.x),
                        obm_pkg::SIZE_BITS'(got.x));
            check_field("merged_y", obm_pkg::SIZE_BITS'(want.y),
                        obm_pkg::SIZE_BITS'(got.y));
            check_field("merged_width", want.w, got.w);
            check_field("merged_height", want.h, got.h);
            check_field("entry_valid", obm_pkg::SIZE_BITS'(want.entry_valid),
                        obm_pkg::SIZE_BITS'(rsp_tuser[0]));
            check_field("table_overflowed", obm_pkg::SIZE_BITS'(want.overflowed),
                        obm_pkg::SIZE_BITS'(rsp_tuser[1]));
            check_field("final_entry", obm_pkg::SIZE_BITS'(want.final_entry),
                        obm_pkg::SIZE_BITS'(rsp_tlast));
         end
      end
   end

   // stimulus
   initial begin
      obm_pkg::box_type  b;
      readout_entry_type none;
      int                sent;
      int                frame_len;
      int                frame_idx;
      int                phase;
      int                pick;
      int                n;
      none = '0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;

      // single empty box, then the largest corner with oversized sizes
      add_row(0, 0, 0, 0, 1'b1, 1'b1,
              {12'd0, 12'd0, 13'd0, 13'd0, 1'b1, 1'b0, 1'b1});
      add_row(MAX_COORD, MAX_COORD, MAX_RAW_SIZE, MAX_RAW_SIZE, 1'b1, 1'b1,
              {12'd4095, 12'd4095, 13'd4096, 13'd4096, 1'b1, 1'b0, 1'b1});
      // close pair merges, disjoint and empty boxes append, big boxes
      // swallow and then saturate the union
      add_row(100, 100, 50, 50, 1'b0, 1'b0, none);
      add_row(102, 102, 50, 50, 1'b0, 1'b0, none);
      add_row(500, 500, 10, 10, 1'b0, 1'b0, none);
      add_row(100, 100, 0, 20, 1'b0, 1'b0, none);
      add_row(0, 0, MAX_SIZE, MAX_SIZE, 1'b0, 1'b0, none);
      add_row(100, 0, MAX_SIZE, MAX_SIZE, 1'b1, 1'b0, none);
      // fill the table with disjoint boxes, the last one is dropped
      for (n = 0; n < obm_pkg::TABLE_DEPTH; n++) begin
         add_row(n * 250, 3000, 20, 20, 1'b0, 1'b0, none);
      end
      add_row(4050, 3000, 20, 20, 1'b1, 1'b0, none);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_box(directed_rows[i].b, directed_rows[i].frame_end,
                  directed_rows[i].typed, directed_rows[i].want);
      end

      // random frames, idling phase changes on frame boundaries
      sent = 0;
      frame_idx = 0;
      while (sent < RANDOM_BOXES) begin
         if (frame_idx % FRAMES_PER_PHASE == 0) begin
            // hold off until the table has been read out completely
            req_tvalid <= 1'b0;
            @(negedge clock);
            while (expected_readout.size() != 0) @(negedge clock);
            phase = (frame_idx / FRAMES_PER_PHASE) % 4;
            case (phase)
               1: begin
                  idle_pct = 73;
                  stall_pct = 0;
               end
               2: begin
                  idle_pct = 0;
                  stall_pct = 73;
               end
               3: begin
                  idle_pct = 17;
                  stall_pct = 17;
               end
               default: begin
                  idle_pct = 0;
                  stall_pct = 0;
               end
            endcase
         end
         pick = int'($urandom_range(99));
         if (pick < 15) frame_len = 1;
         else if (pick < 80) frame_len = int'($urandom_range(2, 10));
         else frame_len = int'($urandom_range(11, 22));
         frame_sent.delete();
         for (n = 0; n < frame_len; n++) begin
            b = random_box();
            frame_sent.insert(frame_sent.size(), b);
            send_box(b, n == frame_len - 1, 1'b0, none);
            sent++;
         end
         frame_idx++;
      end

      // drain
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (expected_readout.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
